FILE: rtl/core/bfdh_pkg.sv
// Package for the double-hash Bloom filter: sizes, configuration indexes,
// request and response types. No dependencies.
package bfdh_pkg;

  localparam int unsigned MAX_BITS      = 1048576;
  localparam int unsigned MAX_HASHES    = 32;
  localparam int unsigned POS_W         = $clog2(MAX_BITS);
  localparam int unsigned CNT_W         = 21;
  localparam int unsigned K_W           = 6;
  localparam int unsigned HASH_W        = 64;
  localparam int unsigned WORD_W        = 32;
  localparam int unsigned BIT_SEL_W     = $clog2(WORD_W);
  localparam int unsigned MEM_DEPTH     = MAX_BITS / WORD_W;
  localparam int unsigned MEM_ADDR_W    = $clog2(MEM_DEPTH);
  localparam int unsigned MOD_STEP_BITS = 4;
  localparam int unsigned MOD_STEPS     = HASH_W / MOD_STEP_BITS;
  localparam int unsigned MOD_CNT_W     = $clog2(MOD_STEPS);
  localparam int unsigned CFG_IDX_W     = 2;

  localparam logic [CNT_W-1:0]     BIT_COUNT_RESET  = CNT_W'(MAX_BITS);
  localparam logic [K_W-1:0]       HASH_COUNT_RESET = K_W'(10);
  localparam logic [CFG_IDX_W-1:0] CFG_BIT_COUNT    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_HASH_COUNT   = CFG_IDX_W'(1);

  typedef struct packed {
    logic              req_type;
    logic [HASH_W-1:0] hash_a;
    logic [HASH_W-1:0] hash_b;
  } req_t;

  typedef struct packed {
    logic             flag;
    logic [CNT_W-1:0] bits_set;
  } rsp_t;

  typedef struct packed {
    logic             done;
    logic [POS_W-1:0] rem;
  } mod_res_t;

endpackage

FILE: rtl/core/bfdh_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module bfdh_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

FILE: rtl/core/bfdh_mod.sv
// Iterative 64-bit by 21-bit remainder unit, four quotient bits per cycle.
// Depends on bfdh_pkg.
module bfdh_mod (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [bfdh_pkg::HASH_W-1:0]   dividend_i,
  input  logic [bfdh_pkg::CNT_W-1:0]    divisor_i,
  output bfdh_pkg::mod_res_t            res_o
);
  import bfdh_pkg::*;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [MOD_CNT_W-1:0] step_q, step_d;
  logic [HASH_W-1:0]    div_q, div_d;
  logic [POS_W-1:0]     rem_q, rem_d;
  logic [CNT_W-1:0]     dvs_q, dvs_d;
  logic [CNT_W:0]       part;
  logic [MOD_STEP_BITS-1:0] nib;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    div_d  = div_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    nib    = div_q[HASH_W-1 -: MOD_STEP_BITS];
    part   = {2'b00, rem_q};
    for (int j = 0; j < MOD_STEP_BITS; j++) begin
      part = {part[CNT_W-1:0], nib[MOD_STEP_BITS-1-j]};
      if (part >= {1'b0, dvs_q}) begin
        part = part - {1'b0, dvs_q};
      end
    end
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      div_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d  = part[POS_W-1:0];
      div_d  = {div_q[HASH_W-MOD_STEP_BITS-1:0], {MOD_STEP_BITS{1'b0}}};
      step_d = step_q + 1'b1;
      if (step_q == MOD_CNT_W'(MOD_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q <= div_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign res_o.done = done_q;
  assign res_o.rem  = rem_q;

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q))
    else $error("remainder done without a running division");
  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> ({1'b0, rem_q} < dvs_q))
    else $error("remainder not below divisor");
  a_no_start_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !start_i)
    else $error("division started while busy");

endmodule

FILE: rtl/core/bloom_filter_double_hash.sv
// Top level of the double-hash Bloom filter: probe sequencer, bit store and
// result register. Depends on bfdh_pkg, bfdh_ram and bfdh_mod.

// After reset the block clears its bit store, one 32-bit word per cycle,
// through all 32768 words; requests are stalled meanwhile, configuration
// writes are taken at any time. Each probe of a request is then an address
// step, one read and one check of the single bit memory; when bit_count is
// not a power of two, each probe also waits for a remainder from the
// iterative divider. One request is in flight at a time; its response sits
// in an output register so the next request can start while it waits.
module bloom_filter_double_hash (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  bfdh_pkg::req_t                 in_req_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output bfdh_pkg::rsp_t                 out_rsp_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [bfdh_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [bfdh_pkg::CNT_W-1:0]     cfg_data_i
);
  import bfdh_pkg::*;

  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_PROBE = 7'b0000100,
    ST_MODW  = 7'b0001000,
    ST_READ  = 7'b0010000,
    ST_CHECK = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic [CNT_W-1:0]      bit_count_q, bit_count_d;
  logic [K_W-1:0]        hash_count_q, hash_count_d;
  logic [CNT_W-1:0]      total_q, total_d;
  logic [MEM_ADDR_W-1:0] clr_q, clr_d;
  logic [K_W-1:0]        cnt_q, cnt_d;
  logic                  out_valid_q, out_valid_d;

  logic                  add_q, add_d;
  logic [HASH_W-1:0]     a_q, a_d;
  logic [HASH_W-1:0]     b_q, b_d;
  logic [CNT_W-1:0]      m_q, m_d;
  logic                  pow2_q, pow2_d;
  logic [K_W-1:0]        k_q, k_d;
  logic [POS_W-1:0]      pos_q, pos_d;
  logic                  all_set_q, all_set_d;
  logic                  any_new_q, any_new_d;
  rsp_t                  rsp_q, rsp_d;

  logic [CNT_W-1:0]      m_eff;
  logic [CNT_W-1:0]      m_dec;
  logic                  in_acc;
  logic                  mod_start;
  mod_res_t              mod_res;
  logic                  ram_we, ram_re;
  logic [MEM_ADDR_W-1:0] ram_waddr;
  logic [WORD_W-1:0]     ram_wdata, ram_rdata;
  logic                  probe_bit;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

  assign m_eff = (bit_count_q == '0 || bit_count_q > CNT_W'(MAX_BITS)) ?
                 CNT_W'(MAX_BITS) : bit_count_q;
  assign m_dec = m_q - 1'b1;
  assign probe_bit = ram_rdata[pos_q[BIT_SEL_W-1:0]];

  always_comb begin
    bit_count_d  = bit_count_q;
    hash_count_d = hash_count_q;
    if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == CFG_BIT_COUNT) begin
        bit_count_d = cfg_data_i;
      end else if (cfg_index_i == CFG_HASH_COUNT) begin
        hash_count_d = cfg_data_i[K_W-1:0];
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    total_d     = total_q;
    clr_d       = clr_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && out_stall_i;
    add_d       = add_q;
    a_d         = a_q;
    b_d         = b_q;
    m_d         = m_q;
    pow2_d      = pow2_q;
    k_d         = k_q;
    pos_d       = pos_q;
    all_set_d   = all_set_q;
    any_new_d   = any_new_q;
    rsp_d       = rsp_q;
    mod_start   = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_waddr   = pos_q[POS_W-1:BIT_SEL_W];
    ram_wdata   = ram_rdata | (WORD_W'(1) << pos_q[BIT_SEL_W-1:0]);
    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + 1'b1;
        if (clr_q == {MEM_ADDR_W{1'b1}}) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          add_d     = in_req_i.req_type;
          a_d       = in_req_i.hash_a;
          b_d       = in_req_i.hash_b;
          m_d       = m_eff;
          pow2_d    = ((m_eff & (m_eff - 1'b1)) == '0);
          k_d       = (hash_count_q > K_W'(MAX_HASHES)) ? K_W'(MAX_HASHES) : hash_count_q;
          cnt_d     = '0;
          all_set_d = 1'b1;
          any_new_d = 1'b0;
          state_d   = (k_d == '0) ? ST_DONE : ST_PROBE;
        end
      end
      ST_PROBE: begin
        a_d   = a_q + b_q;
        b_d   = b_q + HASH_W'(cnt_q);
        cnt_d = cnt_q + 1'b1;
        if (pow2_q) begin
          pos_d   = a_q[POS_W-1:0] & m_dec[POS_W-1:0];
          state_d = ST_READ;
        end else begin
          mod_start = 1'b1;
          state_d   = ST_MODW;
        end
      end
      ST_MODW: begin
        if (mod_res.done) begin
          pos_d   = mod_res.rem;
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        ram_re  = 1'b1;
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (!probe_bit) begin
          all_set_d = 1'b0;
          if (add_q) begin
            ram_we    = 1'b1;
            total_d   = total_q + 1'b1;
            any_new_d = 1'b1;
          end
        end
        state_d = (cnt_q == k_q) ? ST_DONE : ST_PROBE;
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          rsp_d.flag     = add_q ? any_new_q : all_set_q;
          rsp_d.bits_set = total_q;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      bit_count_q  <= BIT_COUNT_RESET;
      hash_count_q <= HASH_COUNT_RESET;
      total_q      <= '0;
      clr_q        <= '0;
      cnt_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      bit_count_q  <= bit_count_d;
      hash_count_q <= hash_count_d;
      total_q      <= total_d;
      clr_q        <= clr_d;
      cnt_q        <= cnt_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    add_q     <= add_d;
    a_q       <= a_d;
    b_q       <= b_d;
    m_q       <= m_d;
    pow2_q    <= pow2_d;
    k_q       <= k_d;
    pos_q     <= pos_d;
    all_set_q <= all_set_d;
    any_new_q <= any_new_d;
    rsp_q     <= rsp_d;
  end

  bfdh_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (a_q),
    .divisor_i  (m_q),
    .res_o      (mod_res)
  );

  bfdh_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MEM_DEPTH)
  ) u_bits (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (pos_q[POS_W-1:BIT_SEL_W]),
    .rdata_o (ram_rdata)
  );

  a_check_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CHECK) |-> ($past(state_q) == ST_READ))
    else $error("bit check without a preceding read");
  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> !ram_re)
    else $error("bit store read and written in one cycle");
  a_probe_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE && state_q != ST_CLEAR) |-> (cnt_q <= k_q))
    else $error("probe count beyond limit");
  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |-> ({1'b0, pos_q} < m_q))
    else $error("probe position outside array");

endmodule
